FILE: rtl/utcl_pkg.sv
// Package: payload types, register indexes and sine constants for the tracking control law.
`timescale 1ns / 1ps
`default_nettype none
package utcl_pkg;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic        [15:0] robot_heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic        [15:0] target_heading;
    logic signed [31:0] target_speed;
    logic signed [31:0] target_turn_rate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive_speed;
    logic signed [31:0] drive_turn_rate;
    logic               speed_gated;
  } out_t;

  localparam logic REG_HEADING_GAIN = 1'b0;
  localparam logic REG_LATERAL_GAIN = 1'b1;

  localparam logic [15:0] GAIN_RESET = 16'd256;

  localparam int SIN_STAGES = 6;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [25:0] SIN_C0 = 26'd307;
  localparam logic [12:0] SIN_C1 = 13'd5223;
  localparam logic [15:0] SIN_C2 = 16'd42334;
  localparam logic [16:0] SIN_C3 = 17'd102944;

endpackage
`default_nettype wire

FILE: rtl/utcl_sine.sv
// Pipelined binary-angle sine: quarter-wave polynomial over six register stages.
`timescale 1ns / 1ps
`default_nettype none
module utcl_sine (
  input  wire logic                               clk,
  input  wire logic [utcl_pkg::SIN_STAGES-1:0]    en,
  input  wire logic [15:0]                        angle,
  output logic signed [17:0]                      sine
);
  import utcl_pkg::*;

  logic [16:0] z1, z2r, z3, z4, z5;
  logic        neg1, neg2, neg3, neg4, neg5;
  logic [16:0] zsq2, zsq3, zsq4;
  logic [12:0] p3;
  logic [15:0] p4;
  logic [16:0] p5;

  logic [14:0] rarg;
  logic [33:0] t2;
  logic [25:0] t3;
  logic [29:0] t4;
  logic [32:0] t5;
  logic [33:0] t6;
  logic [17:0] mag;

  always_comb begin
    rarg = angle[14] ? 15'(17'(QUARTER_TURN) - 17'(angle[13:0]))
                     : {1'b0, angle[13:0]};
    t2   = 34'(z1) * 34'(z1);
    t3   = SIN_C0 * 26'(zsq2);
    t4   = 30'(p3) * 30'(zsq3);
    t5   = 33'(p4) * 33'(zsq4);
    t6   = 34'(p5) * 34'(z5);
    mag  = t6[33:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      z1   <= {rarg, 2'b00};
      neg1 <= angle[15];
    end
    if (en[1]) begin
      zsq2 <= t2[32:16];
      z2r  <= z1;
      neg2 <= neg1;
    end
    if (en[2]) begin
      p3   <= 13'(SIN_C1 - 13'(t3[25:16]));
      zsq3 <= zsq2;
      z3   <= z2r;
      neg3 <= neg2;
    end
    if (en[3]) begin
      p4   <= 16'(SIN_C2 - 16'(t4[29:16]));
      zsq4 <= zsq3;
      z4   <= z3;
      neg4 <= neg3;
    end
    if (en[4]) begin
      p5   <= 17'(SIN_C3 - t5[32:16]);
      z5   <= z4;
      neg5 <= neg4;
    end
    if (en[5]) begin
      sine <= neg5 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/unicycle_tracking_control_law.sv
// Top level: pipelined unicycle trajectory-tracking control law.
`timescale 1ns / 1ps
`default_nettype none
// One pose sample enters per cycle while in_ready is high and passes six
// sine polynomial stages (heading sine, heading cosine, error sine), then
// body-frame rotation and heading gain products, lateral error and feedforward
// sum, lateral gain product and saturating turn sum. A stage holds only while
// the next stage is full and stalled, so bubbles close up and a held output
// does not stop intake until the pipeline is full. Gains are written through
// cfg_we while the block is idle; the user ensures this, the block does not.
module unicycle_tracking_control_law (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire utcl_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output utcl_pkg::out_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [15:0]     cfg_data
);
  import utcl_pkg::*;

  localparam int DEPTH = 10;

  logic [15:0] heading_gain, lateral_gain;
  logic [DEPTH:1] v;
  logic [DEPTH-1:0] en;
  logic [DEPTH:1] take;

  always_comb begin
    take[DEPTH] = !v[DEPTH] || out_ready;
    for (int k = DEPTH - 1; k >= 1; k--) begin
      take[k] = !v[k] || take[k+1];
    end
    en = take[DEPTH:1];
    in_ready = take[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_gain <= GAIN_RESET;
      lateral_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADING_GAIN: heading_gain <= cfg_data;
        REG_LATERAL_GAIN: lateral_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[1] <= in_valid;
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) v[k+1] <= v[k];
      end
    end
  end

  logic [15:0] err_angle, cos_angle;
  logic        gated_in;
  logic signed [17:0] sin_h, cos_h, sin_e;

  always_comb begin
    err_angle = in_data.target_heading - in_data.robot_heading;
    cos_angle = in_data.robot_heading + QUARTER_TURN;
    gated_in  = err_angle[15] ? (err_angle < 16'(17'h10000 - 17'(QUARTER_TURN)))
                              : (err_angle > QUARTER_TURN);
  end

  utcl_sine u_sin_h (.clk(clk), .en(en[SIN_STAGES-1:0]), .angle(in_data.robot_heading),
                     .sine(sin_h));
  utcl_sine u_cos_h (.clk(clk), .en(en[SIN_STAGES-1:0]), .angle(cos_angle), .sine(cos_h));
  utcl_sine u_sin_e (.clk(clk), .en(en[SIN_STAGES-1:0]), .angle(err_angle), .sine(sin_e));

  logic signed [32:0] ex [1:SIN_STAGES];
  logic signed [32:0] ey [1:SIN_STAGES];
  logic signed [31:0] vff [1:DEPTH-1];
  logic signed [31:0] wff [1:SIN_STAGES+1];
  logic               gated [1:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ex[1]    <= 33'(in_data.target_x) - 33'(in_data.robot_x);
      ey[1]    <= 33'(in_data.target_y) - 33'(in_data.robot_y);
      vff[1]   <= in_data.target_speed;
      wff[1]   <= in_data.target_turn_rate;
      gated[1] <= gated_in;
    end
    for (int k = 1; k < SIN_STAGES; k++) begin
      if (en[k]) begin
        ex[k+1] <= ex[k];
        ey[k+1] <= ey[k];
      end
    end
    for (int k = 1; k < SIN_STAGES + 1; k++) begin
      if (en[k]) wff[k+1] <= wff[k];
    end
    for (int k = 1; k < DEPTH - 1; k++) begin
      if (en[k]) begin
        vff[k+1]   <= vff[k];
        gated[k+1] <= gated[k];
      end
    end
  end

  logic signed [50:0] m_s, m_c;
  logic signed [34:0] m_e;
  logic signed [35:0] eyb;
  logic signed [40:0] ff8, ff9;
  logic signed [52:0] m_l;

  logic signed [51:0] lat_sum;
  logic signed [53:0] acc;
  logic signed [45:0] w;
  logic signed [31:0] w_sat;

  always_comb begin
    lat_sum = 52'(m_c) - 52'(m_s);
    acc     = 54'(ff9) + 54'(m_l);
    w       = 46'(acc >>> 8);
    if (w > 46'sd2147483647)       w_sat = 32'sh7fffffff;
    else if (w < -46'sd2147483648) w_sat = 32'sh80000000;
    else                           w_sat = 32'(w);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m_s <= 51'(sin_h) * 51'(ex[SIN_STAGES]);
      m_c <= 51'(cos_h) * 51'(ey[SIN_STAGES]);
      m_e <= $signed({19'd0, heading_gain}) * 35'(sin_e);
    end
    if (en[7]) begin
      eyb <= 36'(lat_sum >>> 16);
      ff8 <= $signed({{1{wff[SIN_STAGES+1][31]}}, wff[SIN_STAGES+1], 8'd0}) + 41'(m_e);
    end
    if (en[8]) begin
      m_l <= $signed({37'd0, lateral_gain}) * 53'(eyb);
      ff9 <= ff8;
    end
    if (en[9]) begin
      out_data.drive_turn_rate <= w_sat;
      out_data.drive_speed     <= gated[DEPTH-1] ? 32'sd0 : vff[DEPTH-1];
      out_data.speed_gated     <= gated[DEPTH-1];
    end
  end

  assign out_valid = v[DEPTH];

endmodule
`default_nettype wire

FILE: rtl/utcl_checker.sv
// Port checker for the tracking control law, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module utcl_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire utcl_pkg::out_t out_data
);
  import utcl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("request dropped or changed while stalled");

  a_gate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.speed_gated |-> out_data.drive_speed == 32'sd0)
    else $error("gated request carries speed");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("intake blocked with empty output");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind unicycle_tracking_control_law utcl_checker u_utcl_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
